// ===== sv/fca_pkg.sv =====
package fca_pkg;

    localparam int NUM_ELEM        = 4;
    localparam int FUSE_FACTOR_DEF = 4;
    localparam int ELEM_W          = 16;
    localparam int Y_W             = 32;
    localparam int PROD_W          = 2 * ELEM_W;
    localparam int CSUM_W          = PROD_W + 1;
    localparam int FRAC_W          = 15;
    localparam int RND_HALF        = 1 << (FRAC_W - 1);
    localparam int SEL_W           = 3;
    localparam int CFG_ADDR_W      = 5;
    localparam int CFG_DATA_W      = 32;

    localparam logic signed [ELEM_W-1:0] ALPHA_RE_RST     = 16'sh7FFF;
    localparam logic signed [ELEM_W-1:0] ALPHA_IM_RST     = 16'sh0000;
    localparam logic [SEL_W-1:0]         COLUMNS_USED_RST = 3'd4;

    // complex q1.15 value
    typedef struct packed {
        logic signed [ELEM_W-1:0] im;
        logic signed [ELEM_W-1:0] re;
    } cplx16_t;

    // the four partial products of one complex multiply
    typedef struct packed {
        logic signed [PROD_W-1:0] rr;
        logic signed [PROD_W-1:0] ii;
        logic signed [PROD_W-1:0] ri;
        logic signed [PROD_W-1:0] ir;
    } prod4_t;

    typedef struct packed {
        logic signed [CSUM_W-1:0] re;
        logic signed [CSUM_W-1:0] im;
    } csum_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] alpha_re;
        logic signed [ELEM_W-1:0] alpha_im;
        logic                     conj_a;
        logic                     conj_x;
        logic [SEL_W-1:0]         columns_used;
    } cfg_t;

    // s is the stored factor, a the operand that may be conjugated later
    function automatic prod4_t cmul_prod(cplx16_t s, cplx16_t a);
        prod4_t p;
        p.rr = PROD_W'(s.re) * PROD_W'(a.re);
        p.ii = PROD_W'(s.im) * PROD_W'(a.im);
        p.ri = PROD_W'(s.re) * PROD_W'(a.im);
        p.ir = PROD_W'(s.im) * PROD_W'(a.re);
        return p;
    endfunction

    // s * a, or s * conj(a) when conj is set
    function automatic csum_t cmul_combine(prod4_t p, logic conj);
        csum_t r;
        if (conj)
        begin
            r.re = CSUM_W'(p.rr) + CSUM_W'(p.ii);
            r.im = CSUM_W'(p.ir) - CSUM_W'(p.ri);
        end
        else
        begin
            r.re = CSUM_W'(p.rr) - CSUM_W'(p.ii);
            r.im = CSUM_W'(p.ri) + CSUM_W'(p.ir);
        end
        return r;
    endfunction

endpackage

// ===== sv/fca_cfg_regs.sv =====
module fca_cfg_regs
    import fca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    typedef enum logic [2:0] {
        REG_ALPHA_RE     = 3'd0,
        REG_ALPHA_IM     = 3'd1,
        REG_CONJ_A       = 3'd2,
        REG_CONJ_X       = 3'd3,
        REG_COLUMNS_USED = 3'd4
    } reg_idx_t;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ALPHA_RE:     cfg_next.alpha_re     = pwdata[ELEM_W-1:0];
                REG_ALPHA_IM:     cfg_next.alpha_im     = pwdata[ELEM_W-1:0];
                REG_CONJ_A:       cfg_next.conj_a       = pwdata[0];
                REG_CONJ_X:       cfg_next.conj_x       = pwdata[0];
                REG_COLUMNS_USED: cfg_next.columns_used = pwdata[SEL_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ALPHA_RE:     prdata = CFG_DATA_W'(cfg_reg.alpha_re);
            REG_ALPHA_IM:     prdata = CFG_DATA_W'(cfg_reg.alpha_im);
            REG_CONJ_A:       prdata = CFG_DATA_W'(cfg_reg.conj_a);
            REG_CONJ_X:       prdata = CFG_DATA_W'(cfg_reg.conj_x);
            REG_COLUMNS_USED: prdata = CFG_DATA_W'(cfg_reg.columns_used);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_re     <= ALPHA_RE_RST;
            cfg_reg.alpha_im     <= ALPHA_IM_RST;
            cfg_reg.conj_a       <= 1'b0;
            cfg_reg.conj_x       <= 1'b0;
            cfg_reg.columns_used <= COLUMNS_USED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/fca_xscale.sv =====
module fca_xscale
    import fca_pkg::*;
#(
    parameter int LANES = NUM_ELEM
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    capture,
    input  cplx16_t x [LANES],
    input  cplx16_t alpha,
    input  logic    update,
    input  logic    conj_x,
    output cplx16_t scaled_x [LANES]
);

    localparam int QW = CSUM_W + 1 - FRAC_W;

    prod4_t  prod_reg   [LANES];
    cplx16_t scaled_reg [LANES];
    cplx16_t scaled_next[LANES];

    function automatic logic signed [ELEM_W-1:0] rnd_sat16(logic signed [CSUM_W-1:0] v);
        logic signed [CSUM_W:0] t;
        logic [QW-1:0]          q;
        logic [QW-ELEM_W:0]     top;
        t   = (CSUM_W + 1)'(v) + (CSUM_W + 1)'(RND_HALF);
        q   = t[CSUM_W:FRAC_W];
        top = q[QW-1:ELEM_W-1];
        if (top == '0 || top == '1)
            return q[ELEM_W-1:0];
        else if (q[QW-1])
            return {1'b1, {(ELEM_W-1){1'b0}}};
        else
            return {1'b0, {(ELEM_W-1){1'b1}}};
    endfunction

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int j = 0; j < LANES; j++)
                prod_reg[j] <= cmul_prod(alpha, x[j]);
        end
    end

    always_comb
    begin
        csum_t c;
        for (int j = 0; j < LANES; j++)
        begin
            c = cmul_combine(prod_reg[j], conj_x);
            if (update)
            begin
                scaled_next[j].re = rnd_sat16(c.re);
                scaled_next[j].im = rnd_sat16(c.im);
            end
            else
            begin
                scaled_next[j] = scaled_reg[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < LANES; j++)
                scaled_reg[j] <= '0;
        end
        else
        begin
            for (int j = 0; j < LANES; j++)
                scaled_reg[j] <= scaled_next[j];
        end
    end

    assign scaled_x = scaled_reg;

endmodule

// ===== sv/fca_row_mac.sv =====
module fca_row_mac
    import fca_pkg::*;
#(
    parameter int LANES = NUM_ELEM
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cplx16_t               a_elem [LANES],
    input  logic signed [Y_W-1:0] y_re,
    input  logic signed [Y_W-1:0] y_im,
    input  logic                  last,
    input  cplx16_t               scaled_x [LANES],
    input  logic                  conj_a,
    input  logic [SEL_W-1:0]      columns_used,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [Y_W-1:0]        out_re,
    output logic [Y_W-1:0]        out_im,
    output logic                  out_sat,
    output logic                  out_last
);

    localparam int SUM_W = CSUM_W + 2;
    localparam int ACC_W = Y_W + FRAC_W + 2;
    localparam int QW    = ACC_W - FRAC_W;

    typedef struct packed {
        logic [Y_W-1:0] val;
        logic           hit;
    } sat_t;

    // product stage
    logic                  p_valid_reg;
    prod4_t                p_prod_reg [LANES];
    prod4_t                p_prod_next[LANES];
    logic signed [Y_W-1:0] p_y_re_reg;
    logic signed [Y_W-1:0] p_y_im_reg;
    logic                  p_last_reg;
    logic                  p_ready;

    // column sum stage
    logic                    s_valid_reg;
    logic signed [SUM_W-1:0] s_sum_re_reg;
    logic signed [SUM_W-1:0] s_sum_im_reg;
    logic signed [SUM_W-1:0] s_sum_re_next;
    logic signed [SUM_W-1:0] s_sum_im_next;
    logic signed [Y_W-1:0]   s_y_re_reg;
    logic signed [Y_W-1:0]   s_y_im_reg;
    logic                    s_last_reg;
    logic                    s_ready;

    // output stage
    logic           o_valid_reg;
    logic [Y_W-1:0] o_re_reg;
    logic [Y_W-1:0] o_im_reg;
    logic           o_sat_reg;
    logic           o_last_reg;
    logic           o_ready;
    sat_t           res_re;
    sat_t           res_im;

    function automatic sat_t rnd_sat32(logic signed [ACC_W-1:0] acc);
        sat_t               r;
        logic [QW-1:0]      q;
        logic [QW-Y_W:0]    top;
        q   = acc[ACC_W-1:FRAC_W];
        top = q[QW-1:Y_W-1];
        if (top == '0 || top == '1)
        begin
            r.val = q[Y_W-1:0];
            r.hit = 1'b0;
        end
        else
        begin
            r.val = q[QW-1] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};
            r.hit = 1'b1;
        end
        return r;
    endfunction

    assign o_ready  = !o_valid_reg || out_ready;
    assign s_ready  = !s_valid_reg || o_ready;
    assign p_ready  = !p_valid_reg || s_ready;
    assign in_ready = p_ready;

    // lanes past the column count add zero
    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            if (SEL_W'(j) < columns_used)
                p_prod_next[j] = cmul_prod(scaled_x[j], a_elem[j]);
            else
                p_prod_next[j] = '0;
        end
    end

    always_comb
    begin
        csum_t c;
        s_sum_re_next = '0;
        s_sum_im_next = '0;
        for (int j = 0; j < LANES; j++)
        begin
            c = cmul_combine(p_prod_reg[j], conj_a);
            s_sum_re_next = s_sum_re_next + SUM_W'(c.re);
            s_sum_im_next = s_sum_im_next + SUM_W'(c.im);
        end
    end

    always_comb
    begin
        logic signed [ACC_W-1:0] acc_re;
        logic signed [ACC_W-1:0] acc_im;
        acc_re = (ACC_W'(s_y_re_reg) <<< FRAC_W) + ACC_W'(s_sum_re_reg) + ACC_W'(RND_HALF);
        acc_im = (ACC_W'(s_y_im_reg) <<< FRAC_W) + ACC_W'(s_sum_im_reg) + ACC_W'(RND_HALF);
        res_re = rnd_sat32(acc_re);
        res_im = rnd_sat32(acc_im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
                p_valid_reg <= in_valid;
            if (s_ready)
                s_valid_reg <= p_valid_reg;
            if (o_ready)
                o_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_ready && in_valid)
        begin
            for (int j = 0; j < LANES; j++)
                p_prod_reg[j] <= p_prod_next[j];
            p_y_re_reg <= y_re;
            p_y_im_reg <= y_im;
            p_last_reg <= last;
        end
        if (s_ready && p_valid_reg)
        begin
            s_sum_re_reg <= s_sum_re_next;
            s_sum_im_reg <= s_sum_im_next;
            s_y_re_reg   <= p_y_re_reg;
            s_y_im_reg   <= p_y_im_reg;
            s_last_reg   <= p_last_reg;
        end
        if (o_ready && s_valid_reg)
        begin
            o_re_reg   <= res_re.val;
            o_im_reg   <= res_im.val;
            o_sat_reg  <= res_re.hit || res_im.hit;
            o_last_reg <= s_last_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_re    = o_re_reg;
    assign out_im    = o_im_reg;
    assign out_sat   = o_sat_reg;
    assign out_last  = o_last_reg;

endmodule

// ===== sv/fused_complex_axpy_rows.sv =====
// row request: result reaches m_tvalid through the input register, column
// staging, products, column sums, and round and saturate
// throughput: one request per cycle unless m_tready stalls; a load request
// yields no result; its scaled x is in place in time for the next row request
// reset: valid bits cleared, registers at defaults, scaled x store all zero
module fused_complex_axpy_rows
    import fca_pkg::*;
#(
    parameter int FUSE_FACTOR = FUSE_FACTOR_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // elem0_re, elem0_im, elem1_re, elem1_im, elem2_re, elem2_im, elem3_re,
    // elem3_im, y_in_re, y_in_im
    input  logic [191:0]          s_tdata,
    // command
    input  logic [0:0]            s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // y_out_re, y_out_im
    output logic [63:0]           m_tdata,
    // saturated
    output logic [0:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int LANES = (FUSE_FACTOR < NUM_ELEM) ? FUSE_FACTOR : NUM_ELEM;
    localparam int Y_LSB = 2 * NUM_ELEM * ELEM_W;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_ROW  = 1'b1
    } cmd_t;

    cfg_t    cfg;
    cplx16_t alpha;
    cplx16_t in_elem [LANES];
    cplx16_t scaled_x[LANES];

    logic                  a_valid_reg;
    cmd_t                  a_cmd_reg;
    cplx16_t               a_elem_reg [LANES];
    logic signed [Y_W-1:0] a_y_re_reg;
    logic signed [Y_W-1:0] a_y_im_reg;
    logic                  a_last_reg;
    logic                  a_ready;

    logic                  b_valid_reg;
    cmd_t                  b_cmd_reg;
    cplx16_t               b_elem_reg [LANES];
    logic signed [Y_W-1:0] b_y_re_reg;
    logic signed [Y_W-1:0] b_y_im_reg;
    logic                  b_last_reg;
    logic                  b_ready;

    logic           mac_in_valid;
    logic           mac_in_ready;
    logic [Y_W-1:0] out_re;
    logic [Y_W-1:0] out_im;
    logic           out_sat;

    fca_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign alpha.re = cfg.alpha_re;
    assign alpha.im = cfg.alpha_im;

    for (genvar j = 0; j < LANES; j++)
    begin : g_unpack
        assign in_elem[j].re = s_tdata[(2 * j) * ELEM_W +: ELEM_W];
        assign in_elem[j].im = s_tdata[(2 * j + 1) * ELEM_W +: ELEM_W];
    end

    // a load leaves the pipe at stage b, a row waits there for the mac
    assign b_ready  = !b_valid_reg || (b_cmd_reg == CMD_LOAD) || mac_in_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_cmd_reg   <= CMD_LOAD;
            b_valid_reg <= 1'b0;
            b_cmd_reg   <= CMD_LOAD;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= s_tvalid;
                if (s_tvalid)
                    a_cmd_reg <= cmd_t'(s_tuser[0]);
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
                if (a_valid_reg)
                    b_cmd_reg <= a_cmd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && s_tvalid)
        begin
            for (int j = 0; j < LANES; j++)
                a_elem_reg[j] <= in_elem[j];
            a_y_re_reg <= s_tdata[Y_LSB +: Y_W];
            a_y_im_reg <= s_tdata[Y_LSB + Y_W +: Y_W];
            a_last_reg <= s_tlast;
        end
        if (b_ready && a_valid_reg)
        begin
            for (int j = 0; j < LANES; j++)
                b_elem_reg[j] <= a_elem_reg[j];
            b_y_re_reg <= a_y_re_reg;
            b_y_im_reg <= a_y_im_reg;
            b_last_reg <= a_last_reg;
        end
    end

    fca_xscale #(
        .LANES (LANES)
    ) u_xscale (
        .clk      (clk),
        .rst_n    (rst_n),
        .capture  (b_ready && a_valid_reg && (a_cmd_reg == CMD_LOAD)),
        .x        (a_elem_reg),
        .alpha    (alpha),
        .update   (b_valid_reg && (b_cmd_reg == CMD_LOAD)),
        .conj_x   (cfg.conj_x),
        .scaled_x (scaled_x)
    );

    assign mac_in_valid = b_valid_reg && (b_cmd_reg == CMD_ROW);

    fca_row_mac #(
        .LANES (LANES)
    ) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (mac_in_valid),
        .in_ready     (mac_in_ready),
        .a_elem       (b_elem_reg),
        .y_re         (b_y_re_reg),
        .y_im         (b_y_im_reg),
        .last         (b_last_reg),
        .scaled_x     (scaled_x),
        .conj_a       (cfg.conj_a),
        .columns_used (cfg.columns_used),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_re       (out_re),
        .out_im       (out_im),
        .out_sat      (out_sat),
        .out_last     (m_tlast)
    );

    assign m_tdata = {out_im, out_re};
    assign m_tuser = out_sat;

endmodule
